[rtl/core/sqrot_pkg.sv]
package sqrot_pkg;

   // Field widths fixed by the interface
   localparam int DATA_WIDTH = 32;
   localparam int SIDE_WIDTH = 4;

   // Default largest side and reset value of the side register
   localparam int              MAX_SIDE_DEFAULT = 8;
   localparam logic [SIDE_WIDTH-1:0] SIDE_RESET = 4'd8;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;   // side register write: restart loading
      logic load;    // store the accepted element
      logic start;   // set up address generation for the rotated read-out
      logic issue;   // read one element of the rotated matrix
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic load_last;   // element at the load pointer completes the matrix
      logic issue_last;  // current read is the last of the rotated matrix
   } status_type;

endpackage

[rtl/core/square_matrix_rotate_clockwise.sv]
// Channel      Ports                                        Handshake
// input        req_element_value                            start high, busy low
// result       rsp_rotated_value, rsp_final_flag            rsp_strobe, one cycle
// config       csr_side_length                              csr_write_enable
//
// Elements load one per cycle into the element store while busy is low.
// The element that completes an n-by-n matrix starts read-out: busy is high
// while its n*n elements are read, one store read per cycle; each result
// appears the cycle after its read, through the read data register.
// Synchronous reset clears the controller, load pointer and strobe; the side
// register resets to 8. The receiver cannot stall; results are never held.
module square_matrix_rotate_clockwise #(
   parameter int MAX_SIDE = sqrot_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [sqrot_pkg::DATA_WIDTH-1:0] req_element_value,
   output logic                                    rsp_strobe,
   output logic signed [sqrot_pkg::DATA_WIDTH-1:0] rsp_rotated_value,
   output logic                                    rsp_final_flag,
   input  logic                                    csr_write_enable,
   input  logic [sqrot_pkg::SIDE_WIDTH-1:0]        csr_side_length
);

   sqrot_pkg::cmd_type    cmd;
   sqrot_pkg::status_type status;

   sqrot_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd),
      .busy             (busy)
   );

   sqrot_dpath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_side_length   (csr_side_length),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_rotated_value (rsp_rotated_value),
      .rsp_final_flag    (rsp_final_flag)
   );

endmodule

[rtl/core/sqrot_ctrl.sv]
module sqrot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  csr_write_enable,
   input  sqrot_pkg::status_type status,
   output sqrot_pkg::cmd_type    cmd,
   output logic                  busy
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;

   // Command decode
   always_comb begin
      cmd.clear = csr_write_enable;
      cmd.load  = start && (state_ff == ST_LOAD);
      cmd.start = cmd.load && status.load_last;
      cmd.issue = (state_ff == ST_EMIT);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd.start) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.issue_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_EMIT);

endmodule

[rtl/core/sqrot_dpath.sv]
module sqrot_dpath #(
   parameter int MAX_SIDE = sqrot_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sqrot_pkg::cmd_type                     cmd,
   output sqrot_pkg::status_type                  status,
   input  logic [sqrot_pkg::SIDE_WIDTH-1:0]       csr_side_length,
   input  logic signed [sqrot_pkg::DATA_WIDTH-1:0] req_element_value,
   output logic                                   rsp_strobe,
   output logic signed [sqrot_pkg::DATA_WIDTH-1:0] rsp_rotated_value,
   output logic                                   rsp_final_flag
);

   localparam int Depth  = MAX_SIDE * MAX_SIDE;
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);
   localparam int SideW  = $clog2(MAX_SIDE + 1);
   localparam int PosW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   logic [sqrot_pkg::SIDE_WIDTH-1:0] side_ff;
   logic [SideW-1:0]                 side_eff;
   logic [CountW-1:0]                total;
   logic [CountW-1:0]                load_count_ff;
   logic [CountW-1:0]                load_next;
   logic [CountW-1:0]                emit_count_ff;
   logic [AddrW-1:0]                 rd_addr_ff;
   logic [AddrW-1:0]                 base_ff;
   logic [PosW-1:0]                  row_ff;
   logic [PosW-1:0]                  col_ff;
   logic                             col_last;
   logic signed [sqrot_pkg::DATA_WIDTH-1:0] store [Depth];
   logic signed [sqrot_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_final_ff;

   // Side register
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= sqrot_pkg::SIDE_RESET;
      end else if (cmd.clear) begin
         side_ff <= csr_side_length;
      end
   end

   // Effective side: zero reads as one, large values saturate
   always_comb begin
      priority if (side_ff == '0) begin
         side_eff = SideW'(1);
      end else if (side_ff > sqrot_pkg::SIDE_WIDTH'(MAX_SIDE)) begin
         side_eff = SideW'(MAX_SIDE);
      end else begin
         side_eff = SideW'(side_ff);
      end
   end

   assign total     = CountW'(side_eff) * CountW'(side_eff);
   assign load_next = load_count_ff + CountW'(1);
   assign col_last  = (SideW'(col_ff) == (side_eff - SideW'(1)));

   assign status.load_last  = (load_next == total);
   assign status.issue_last = (emit_count_ff == (total - CountW'(1)));

   // Load pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else if (cmd.clear) begin
         load_count_ff <= '0;
      end else if (cmd.load) begin
         load_count_ff <= status.load_last ? '0 : load_next;
      end
   end

   // Element store write port
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store[load_count_ff[AddrW-1:0]] <= req_element_value;
      end
   end

   // Element store read port
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= store[rd_addr_ff];
      end
   end

   // Rotated address walk: column c of output row r reads (n-1-c)*n + r
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
      end else if (cmd.start) begin
         emit_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
      end else if (cmd.issue) begin
         emit_count_ff <= emit_count_ff + CountW'(1);
         if (col_last) begin
            col_ff <= '0;
            row_ff <= row_ff + PosW'(1);
         end else begin
            col_ff <= col_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         base_ff    <= AddrW'(total - CountW'(side_eff));
         rd_addr_ff <= AddrW'(total - CountW'(side_eff));
      end else if (cmd.issue) begin
         if (col_last) begin
            rd_addr_ff <= base_ff + AddrW'(row_ff) + AddrW'(1);
         end else begin
            rd_addr_ff <= rd_addr_ff - AddrW'(side_eff);
         end
      end
   end

   // Result strobe and final marker, registered together with the read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_final_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.issue;
         rsp_final_ff <= cmd.issue && status.issue_last;
      end
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_rotated_value = rd_data_ff;
   assign rsp_final_flag    = rsp_final_ff;

endmodule

[rtl/core/sqrot_checker.sv]
module sqrot_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_final_flag
);

   // Results only follow a read-out cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding read-out cycle");

   // End of read-out coincides with the final transaction
   a_fall_is_final: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_final_flag))
      else $error("read-out ended without final transaction");

   // A final transaction is never followed directly by another result
   a_gap_after_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_flag) |=> !rsp_strobe)
      else $error("result directly after final transaction");

   // Read-out only begins on an accepted element
   a_rise_on_start: assert property (@(posedge clock) disable iff (reset)
      ($rose(busy) && !$past(reset)) |-> $past(start))
      else $error("read-out began without an accepted element");

endmodule

bind square_matrix_rotate_clockwise sqrot_checker u_sqrot_checker (.*);
